[rtl/button_gesture_detector_unit_macros.svh]
// assertion macros used by the button gesture detector result queue
// expects clk and arst_n in the scope of each use
`ifndef BUTTON_GESTURE_DETECTOR_UNIT_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BGD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bgd assertion failed");
`define BGD_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("bgd forbidden condition seen");
`else
`define BGD_ASSERT(label, prop)
`define BGD_ASSERT_NEVER(label, cond)
`endif
`endif

[rtl/bgd_pkg.sv]
// shared types, codes and helpers of the button gesture detector
// no dependencies
package bgd_pkg;

	// one scan tick
	typedef struct packed {
		logic [3:0] button_index;
		logic       pin_level;
	} bgd_in_t;

	// one reported event
	typedef struct packed {
		logic [3:0] button_id;
		logic [2:0] event_code;
		logic       fired;
		logic       last;
	} bgd_out_t;

	// per-button gesture phase
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_PRESSED  = 3'd1,
		PH_RELEASED = 3'd2,
		PH_SECOND   = 3'd3,
		PH_HOLD     = 3'd4
	} phase_t;

	// event codes
	localparam logic [2:0] EV_IDLE   = 3'd0;
	localparam logic [2:0] EV_DOWN   = 3'd1;
	localparam logic [2:0] EV_UP     = 3'd2;
	localparam logic [2:0] EV_SINGLE = 3'd3;
	localparam logic [2:0] EV_DOUBLE = 3'd4;
	localparam logic [2:0] EV_HSTART = 3'd5;
	localparam logic [2:0] EV_HEND   = 3'd6;

	// configuration register indexes
	localparam logic [1:0] CFG_SCAN_PERIOD   = 2'd0;
	localparam logic [1:0] CFG_HOLD_THR      = 2'd1;
	localparam logic [1:0] CFG_DEBOUNCE_THR  = 2'd2;
	localparam logic [1:0] CFG_RELEASE_THR   = 2'd3;

	localparam logic [7:0]  SCAN_PERIOD_RST  = 8'd10;
	localparam logic [15:0] HOLD_THR_RST     = 16'd1000;
	localparam logic [15:0] DEBOUNCE_THR_RST = 16'd20;
	localparam logic [15:0] RELEASE_THR_RST  = 16'd300;

	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	// result queue geometry
	localparam int RES_DEPTH = 8;
	localparam int RES_PTR_W = 3;
	localparam int RES_CNT_W = RES_PTR_W + 1;

	// stored state of one button
	typedef struct packed {
		phase_t      phase;
		logic [2:0]  cur_event;
		logic [15:0] hold_count;
		logic [15:0] release_count;
	} bgd_entry_t;

	localparam bgd_entry_t ENTRY_RST = '{
		phase: PH_IDLE, cur_event: EV_IDLE, hold_count: 16'd0, release_count: 16'd0};

	typedef struct packed {
		logic [7:0]  scan_period;
		logic [15:0] hold_thr;
		logic [15:0] debounce_thr;
		logic [15:0] release_thr;
	} bgd_cfg_t;

	// counter advance with saturation
	function automatic logic [15:0] sat_add(input logic [15:0] c, input logic [7:0] p);
		logic [16:0] s;
		s = {1'b0, c} + {9'd0, p};
		return s[16] ? CNT_MAX : s[15:0];
	endfunction

endpackage

[rtl/button_gesture_detector_unit.sv]
// Button gesture detector: click, double click and long-hold detection
// for interleaved scan ticks of up to NUM_BUTTONS buttons.
// Input channel (in_valid/in_ready/in_data): one scan tick, a button index
// and its pin level. Output channel (out_valid/out_ready/out_data): event
// items; a tick gives one item, or two (press up, then hold end) when a
// long hold ends. Config port: cfg_we writes cfg_wdata to register cfg_index
// (scan period, hold, debounce and release thresholds) in the same cycle.
// The first item of a tick is offered once the tick has passed the stage 1
// registers with the state memory read and has been written into the queue.
// Throughput: one tick per cycle while in_ready is high; the per-button state
// memory is read in the accept cycle and written back the next, a write
// colliding with the following read of the same button is forwarded.
// A two-item tick enters the queue at once and leaves it one item at a time.
// Reset: every button idle with zero counters, registers at their defaults;
// no clearing pass, entries read as idle until first written.
// Output stall: results wait in an eight-entry queue; in_ready drops while
// the queue cannot take two more items beyond the tick in flight.
// depends on bgd_pkg, bgd_state_mem, bgd_step, bgd_result_fifo
module button_gesture_detector_unit #(
	parameter int NUM_BUTTONS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bgd_pkg::bgd_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output bgd_pkg::bgd_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_wdata
);
	import bgd_pkg::*;

	localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	bgd_cfg_t             cfg_q;
	logic                 valid_s1;
	bgd_in_t              data_s1;
	logic                 in_range_s1;
	logic [AW-1:0]        addr_s1;
	logic                 accept;
	logic [AW+3:0]        idx_ext;
	logic                 in_range;
	logic [AW-1:0]        rd_addr;
	bgd_entry_t           rd_entry;
	bgd_entry_t           next_entry;
	logic                 two_results;
	bgd_out_t             res0;
	bgd_out_t             res1;
	logic [RES_CNT_W-1:0] res_count;
	logic [RES_CNT_W:0]   committed;

	// input address decode
	assign idx_ext  = {{AW{1'b0}}, in_data.button_index};
	assign in_range = idx_ext < (AW + 4)'(NUM_BUTTONS);
	assign rd_addr  = in_range ? idx_ext[AW-1:0] : '0;
	assign accept   = in_valid && in_ready;

	// take a tick only if the queue has room for it and the tick in flight
	assign committed = {1'b0, res_count} + (valid_s1 ? (RES_CNT_W + 1)'(2) : '0);
	assign in_ready  = committed <= (RES_CNT_W + 1)'(RES_DEPTH - 2);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_period  <= SCAN_PERIOD_RST;
			cfg_q.hold_thr     <= HOLD_THR_RST;
			cfg_q.debounce_thr <= DEBOUNCE_THR_RST;
			cfg_q.release_thr  <= RELEASE_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCAN_PERIOD:  cfg_q.scan_period  <= cfg_wdata[7:0];
				CFG_HOLD_THR:     cfg_q.hold_thr     <= cfg_wdata;
				CFG_DEBOUNCE_THR: cfg_q.debounce_thr <= cfg_wdata;
				CFG_RELEASE_THR:  cfg_q.release_thr  <= cfg_wdata;
			endcase
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1     <= in_data;
			in_range_s1 <= in_range;
			addr_s1     <= rd_addr;
		end
	end

	bgd_state_mem #(
		.DEPTH (NUM_BUTTONS),
		.AW    (AW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (rd_addr),
		.wr_en    (valid_s1 && in_range_s1),
		.wr_addr  (addr_s1),
		.wr_data  (next_entry),
		.rd_entry (rd_entry)
	);

	bgd_step u_step (
		.entry       (rd_entry),
		.cfg         (cfg_q),
		.button_id   (data_s1.button_index),
		.pin_level   (data_s1.pin_level),
		.in_range    (in_range_s1),
		.next_entry  (next_entry),
		.two_results (two_results),
		.res0        (res0),
		.res1        (res1)
	);

	bgd_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_one  (valid_s1),
		.push_two  (valid_s1 && two_results),
		.res0      (res0),
		.res1      (res1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.count     (res_count)
	);

endmodule

[rtl/bgd_state_mem.sv]
// per-button state memory with registered read, valid bits and write forwarding
// depends on bgd_pkg
module bgd_state_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  bgd_pkg::bgd_entry_t wr_data,
	output bgd_pkg::bgd_entry_t rd_entry
);
	import bgd_pkg::*;

	bgd_entry_t       mem [DEPTH];
	bgd_entry_t       rdata_q;
	logic [AW-1:0]    addr_q;
	logic [DEPTH-1:0] valid_q;
	logic             byp_valid_q;
	logic [AW-1:0]    byp_addr_q;
	bgd_entry_t       byp_data_q;

	// storage array and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			addr_q  <= rd_addr;
		end
		byp_addr_q <= wr_addr;
		byp_data_q <= wr_data;
	end

	// entry valid bits and forwarding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			byp_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			byp_valid_q <= wr_en;
		end
	end

	// write at the read edge wins, unwritten entries read as reset state
	always_comb begin
		if (byp_valid_q && byp_addr_q == addr_q) begin
			rd_entry = byp_data_q;
		end else if (valid_q[addr_q]) begin
			rd_entry = rdata_q;
		end else begin
			rd_entry = ENTRY_RST;
		end
	end

endmodule

[rtl/bgd_step.sv]
// gesture phase update for one scan tick of one button
// depends on bgd_pkg
module bgd_step (
	input  bgd_pkg::bgd_entry_t entry,
	input  bgd_pkg::bgd_cfg_t   cfg,
	input  logic [3:0]          button_id,
	input  logic                pin_level,
	input  logic                in_range,
	output bgd_pkg::bgd_entry_t next_entry,
	output logic                two_results,
	output bgd_pkg::bgd_out_t   res0,
	output bgd_pkg::bgd_out_t   res1
);
	import bgd_pkg::*;

	logic [15:0] hold_inc;
	logic [15:0] rel_inc;
	logic        fired;
	logic        hold_end;

	assign hold_inc = sat_add(entry.hold_count, cfg.scan_period);
	assign rel_inc  = sat_add(entry.release_count, cfg.scan_period);

	// phase transitions
	always_comb begin
		next_entry = entry;
		fired      = 1'b0;
		hold_end   = 1'b0;
		unique case (entry.phase)
			PH_IDLE: begin
				next_entry.cur_event     = pin_level ? EV_DOWN : EV_IDLE;
				next_entry.phase         = pin_level ? PH_PRESSED : PH_IDLE;
				next_entry.hold_count    = 16'd0;
				next_entry.release_count = 16'd0;
				fired                    = 1'b1;
			end
			PH_PRESSED: begin
				next_entry.hold_count = hold_inc;
				if (pin_level) begin
					if (hold_inc > cfg.hold_thr) begin
						next_entry.phase     = PH_HOLD;
						next_entry.cur_event = EV_HSTART;
						fired                = 1'b1;
					end
				end else if (hold_inc > cfg.debounce_thr) begin
					next_entry.phase     = PH_RELEASED;
					next_entry.cur_event = EV_UP;
					fired                = 1'b1;
				end else begin
					next_entry.phase     = PH_IDLE;
					next_entry.cur_event = EV_IDLE;
					fired                = 1'b1;
				end
			end
			PH_RELEASED: begin
				if (pin_level) begin
					next_entry.hold_count = hold_inc;
					if (hold_inc > cfg.debounce_thr) begin
						next_entry.phase     = PH_SECOND;
						next_entry.cur_event = EV_DOWN;
						fired                = 1'b1;
					end
				end else begin
					next_entry.release_count = rel_inc;
					if (rel_inc > cfg.release_thr) begin
						next_entry.phase     = PH_IDLE;
						next_entry.cur_event = EV_SINGLE;
						fired                = 1'b1;
					end
				end
			end
			PH_SECOND: begin
				if (pin_level) begin
					next_entry.hold_count = hold_inc;
				end else begin
					next_entry.phase     = PH_IDLE;
					next_entry.cur_event = EV_DOUBLE;
					fired                = 1'b1;
				end
			end
			PH_HOLD: begin
				if (pin_level) begin
					next_entry.hold_count = hold_inc;
				end else begin
					next_entry.phase     = PH_IDLE;
					next_entry.cur_event = EV_HEND;
					hold_end             = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result items of this tick
	always_comb begin
		res0        = '{button_id: button_id, event_code: next_entry.cur_event,
			fired: fired, last: 1'b1};
		res1        = '{button_id: button_id, event_code: EV_HEND, fired: 1'b1, last: 1'b1};
		two_results = 1'b0;
		if (!in_range) begin
			res0 = '{button_id: button_id, event_code: EV_IDLE, fired: 1'b0, last: 1'b1};
		end else if (hold_end) begin
			// end of a long hold reports press up first
			res0        = '{button_id: button_id, event_code: EV_UP, fired: 1'b1, last: 1'b0};
			two_results = 1'b1;
		end
	end

endmodule

[rtl/bgd_result_fifo.sv]
// result queue that takes one or two items a cycle and gives one while out_ready is high
// depends on bgd_pkg and the assertion macro header
`include "button_gesture_detector_unit_macros.svh"
module bgd_result_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push_one,
	input  logic                          push_two,
	input  bgd_pkg::bgd_out_t             res0,
	input  bgd_pkg::bgd_out_t             res1,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bgd_pkg::bgd_out_t             out_data,
	output logic [bgd_pkg::RES_CNT_W-1:0] count
);
	import bgd_pkg::*;

	bgd_out_t               fifo_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wr_ptr_q;
	logic [RES_PTR_W-1:0]   rd_ptr_q;
	logic [RES_CNT_W-1:0]   count_q;
	logic [RES_PTR_W-1:0]   wr_ptr_nx;
	logic                   pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign out_data  = fifo_q[rd_ptr_q];
	assign count     = count_q;
	assign wr_ptr_nx = wr_ptr_q + RES_PTR_W'(1);

	// storage
	always_ff @(posedge clk) begin
		if (push_one) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (push_two) begin
			fifo_q[wr_ptr_nx] <= res1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_one) + RES_PTR_W'(push_two);
			rd_ptr_q <= rd_ptr_q + RES_PTR_W'(pop);
			count_q  <= count_q + RES_CNT_W'(push_one) + RES_CNT_W'(push_two)
				- RES_CNT_W'(pop);
		end
	end

	`BGD_ASSERT_NEVER(a_no_overflow, count_q > RES_CNT_W'(RES_DEPTH))
	`BGD_ASSERT(a_idle_count_holds, (!push_one && !pop) |=> $stable(count_q))
	`BGD_ASSERT(a_pair_marks_last, push_two |-> (push_one && !res0.last && res1.last))
	`BGD_ASSERT(a_single_is_last, (push_one && !push_two) |-> res0.last)

endmodule
